/* rtl/core/srsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_pkg: shared types and constants of the slotted record stream parser
// Phase codes, event kinds and the word that travels from front to back.
// ----------------------------------------------------------------------------
package srsp_pkg;

  localparam int unsigned SlotSizeW   = 20;
  localparam int unsigned SlotSizeRst = 256;
  localparam int unsigned OffW        = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam logic [31:0] MagicWord   = 32'h6C33336C;
  localparam logic [31:0] RecStart    = 32'd17;

  typedef enum logic [3:0] {
    EV_ITEM_START = 4'd0,
    EV_INT        = 4'd1,
    EV_STR_BYTE   = 4'd2,
    EV_STR_END    = 4'd3,
    EV_BLOB_START = 4'd4,
    EV_BLOB_BYTE  = 4'd5,
    EV_ITEM_END   = 4'd6,
    EV_BAD_MAGIC  = 4'd7,
    EV_UNKNOWN    = 4'd8,
    EV_OVERRUN    = 4'd9
  } ev_kind_e;

  typedef enum logic [13:0] {
    PH_MAGIC     = 14'b00000000000001,
    PH_LEN       = 14'b00000000000010,
    PH_SEQ       = 14'b00000000000100,
    PH_PAD       = 14'b00000000001000,
    PH_TYPE      = 14'b00000000010000,
    PH_CODE_INT  = 14'b00000000100000,
    PH_CODE_STR  = 14'b00000001000000,
    PH_CODE_BLOB = 14'b00000010000000,
    PH_INTVAL    = 14'b00000100000000,
    PH_STR       = 14'b00001000000000,
    PH_BLOBLEN   = 14'b00010000000000,
    PH_BLOBDATA  = 14'b00100000000000,
    PH_CLOSING   = 14'b01000000000000,
    PH_SKIP      = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] code;
    logic [63:0] value;
    logic [7:0]  data;
  } event_t;

endpackage
`default_nettype wire

/* rtl/core/srsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_front: byte parser
// Tracks the slot phase of each accepted byte and classifies it into at most
// one event, which it drives combinationally on ev_o and ev_valid_o.
// ----------------------------------------------------------------------------
module srsp_front import srsp_pkg::*; #(
  parameter int unsigned SlotW = SlotSizeW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SlotW-1:0] slot_size_i,
  input  wire logic             byte_valid_i,
  input  wire logic [7:0]       byte_i,
  output event_t                ev_o,
  output logic                  ev_valid_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] off_q, off_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] area_end_q, area_end_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  grp_q, grp_d;
  logic [31:0] code_q, code_d;
  logic [31:0] rem_q, rem_d;

  logic [31:0] slot_end;
  logic [63:0] acc_fed;
  logic [3:0]  grp_fed;
  logic        vend;
  logic [31:0] hdr_word;
  phase_e      rec_done_ph;
  logic [31:0] rem_dec;

  assign slot_end = 32'(slot_size_i) + 32'd8;
  assign vend     = ~byte_i[7];
  assign rem_dec  = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
  assign rec_done_ph = ((off_q + 32'd1) >= area_end_q) ? PH_CLOSING : PH_TYPE;

  // One varint group per byte; the 7-bit groups land at a shift of 7*count.
  always_comb begin
    acc_fed = acc_q;
    grp_fed = grp_q;
    if (grp_q < 4'd10) begin
      acc_fed = acc_q | (64'(byte_i[6:0]) << (7 * grp_q));
      grp_fed = grp_q + 4'd1;
    end
  end

  always_comb begin
    hdr_word = shift_q;
    case (off_q[1:0])
      2'd0:    hdr_word = {24'd0, byte_i};
      2'd1:    hdr_word = {shift_q[31:16], byte_i, shift_q[7:0]};
      2'd2:    hdr_word = {shift_q[31:24], byte_i, shift_q[15:0]};
      default: hdr_word = {byte_i, shift_q[23:0]};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    off_d      = off_q;
    shift_d    = shift_q;
    area_end_d = area_end_q;
    acc_d      = acc_q;
    grp_d      = grp_q;
    code_d     = code_q;
    rem_d      = rem_q;
    ev_valid_o = 1'b0;
    ev_o       = '{kind: EV_ITEM_START, code: 32'd0, value: 64'd0, data: 8'd0};
    if (byte_valid_i) begin
      off_d = off_q + 32'd1;
      if (phase_q != PH_MAGIC && off_q >= slot_end) begin
        if (phase_q == PH_CLOSING) begin
          ev_valid_o = 1'b1;
          ev_o.kind  = EV_ITEM_END;
        end else if (phase_q != PH_SKIP) begin
          ev_valid_o = 1'b1;
          ev_o.kind  = EV_OVERRUN;
        end
        phase_d = PH_MAGIC;
        shift_d = {24'd0, byte_i};
        off_d   = 32'd1;
      end else begin
        if (phase_q == PH_MAGIC || phase_q == PH_LEN || phase_q == PH_SEQ) begin
          shift_d = hdr_word;
        end
        case (phase_q)
          PH_MAGIC: begin
            if (off_q >= 32'd3) begin
              if (hdr_word == MagicWord) begin
                phase_d = PH_LEN;
              end else begin
                ev_valid_o = 1'b1;
                ev_o.kind  = EV_BAD_MAGIC;
                ev_o.value = 64'(hdr_word);
                off_d      = 32'd0;
              end
            end
          end
          PH_LEN: begin
            if (off_q >= 32'd7) begin
              area_end_d = hdr_word[31] ? 32'd0 : hdr_word + 32'd8;
              phase_d    = PH_SEQ;
            end
          end
          PH_SEQ: begin
            if (off_q >= 32'd11) begin
              ev_valid_o = 1'b1;
              ev_o.kind  = EV_ITEM_START;
              ev_o.value = 64'(hdr_word);
              phase_d    = PH_PAD;
            end
          end
          PH_PAD: begin
            if (off_q >= RecStart - 32'd1) begin
              phase_d = (RecStart >= area_end_q) ? PH_CLOSING : PH_TYPE;
            end
          end
          PH_TYPE: begin
            acc_d = 64'd0;
            grp_d = 4'd0;
            case (byte_i)
              8'd0:    phase_d = PH_CODE_INT;
              8'd3:    phase_d = PH_CODE_STR;
              8'd4:    phase_d = PH_CODE_BLOB;
              default: begin
                ev_valid_o = 1'b1;
                ev_o.kind  = EV_UNKNOWN;
                ev_o.data  = byte_i;
                phase_d    = PH_SKIP;
              end
            endcase
          end
          PH_CODE_INT, PH_CODE_STR, PH_CODE_BLOB: begin
            acc_d = acc_fed;
            grp_d = grp_fed;
            if (vend) begin
              code_d = acc_fed[31:0];
              acc_d  = 64'd0;
              grp_d  = 4'd0;
              if (phase_q == PH_CODE_INT) begin
                phase_d = PH_INTVAL;
              end else if (phase_q == PH_CODE_STR) begin
                phase_d = PH_STR;
              end else begin
                phase_d = PH_BLOBLEN;
              end
            end
          end
          PH_INTVAL: begin
            acc_d = acc_fed;
            grp_d = grp_fed;
            if (vend) begin
              ev_valid_o = 1'b1;
              ev_o.kind  = EV_INT;
              ev_o.code  = code_q;
              ev_o.value = acc_fed;
              acc_d      = 64'd0;
              grp_d      = 4'd0;
              phase_d    = rec_done_ph;
            end
          end
          PH_STR: begin
            ev_valid_o = 1'b1;
            ev_o.code  = code_q;
            if (byte_i != 8'd0) begin
              ev_o.kind = EV_STR_BYTE;
              ev_o.data = byte_i;
            end else begin
              ev_o.kind = EV_STR_END;
              phase_d   = rec_done_ph;
            end
          end
          PH_BLOBLEN: begin
            acc_d = acc_fed;
            grp_d = grp_fed;
            if (vend) begin
              ev_valid_o = 1'b1;
              ev_o.kind  = EV_BLOB_START;
              ev_o.code  = code_q;
              ev_o.value = acc_fed;
              rem_d      = (acc_fed[63:32] != 32'd0) ? 32'hFFFFFFFF : acc_fed[31:0];
              acc_d      = 64'd0;
              grp_d      = 4'd0;
              phase_d    = (acc_fed == 64'd0) ? rec_done_ph : PH_BLOBDATA;
            end
          end
          PH_BLOBDATA: begin
            ev_valid_o = 1'b1;
            ev_o.kind  = EV_BLOB_BYTE;
            ev_o.code  = code_q;
            ev_o.data  = byte_i;
            rem_d      = rem_dec;
            if (rem_dec == 32'd0) begin
              phase_d = rec_done_ph;
            end
          end
          PH_CLOSING: begin
            ev_valid_o = 1'b1;
            ev_o.kind  = EV_ITEM_END;
            phase_d    = PH_SKIP;
          end
          default: phase_d = PH_SKIP;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      off_q      <= '0;
      shift_q    <= '0;
      area_end_q <= '0;
      acc_q      <= '0;
      grp_q      <= '0;
      code_q     <= '0;
      rem_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      off_q      <= off_d;
      shift_q    <= shift_d;
      area_end_q <= area_end_d;
      acc_q      <= acc_d;
      grp_q      <= grp_d;
      code_q     <= code_d;
      rem_q      <= rem_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("phase register lost its one-hot code");
  a_grp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) grp_q <= 4'd10)
    else $error("varint group count above ten");
  a_magic_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && phase_q == PH_MAGIC && off_q >= 32'd3 && !ev_valid_o) |=>
      phase_q == PH_LEN)
    else $error("matched magic did not advance to length");

endmodule
`default_nettype wire

/* rtl/core/srsp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_queue: event queue
// Small FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module srsp_queue import srsp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire event_t push_data_i,
  input  wire logic   push_i,
  output logic        full_o,
  output logic        almost_full_o,
  output event_t      pop_data_o,
  output logic        empty_o,
  input  wire logic   pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  event_t        mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o        = (cnt_q == (AW+1)'(Depth));
  assign almost_full_o = (cnt_q >= (AW+1)'(Depth - 1));
  assign empty_o       = (cnt_q == '0);
  assign pop_data_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !pop_i) |=> cnt_q == $past(cnt_q) + (AW+1)'(1))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

/* rtl/core/slotted_record_stream_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slotted_record_stream_parser_top: slotted record stream parser
// Splits a byte stream into slots and emits one typed event per byte at most.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte per word. Each byte yields zero or one
//   event word on the master channel: item start, record fields, string and
//   blob bytes, item end, bad magic, unknown type or overrun.
//   slot_size is written through cfg_we_i / cfg_wdata_i; the user must write
//   it only while the block idles, and the block itself does not enforce it.
// Event path: an accepted byte's event goes to a staging register, then the
//   queue, then the output register, which reloads once empty or taken.
// Throughput: one byte per cycle while the master side takes its words; the
//   parser advances one byte per cycle and the four-entry queue absorbs
//   short stalls.
// Stall: when the queue cannot take both the staged event and one more,
//   s_axis_tready falls, so no event is ever dropped.
// Reset: rst_ni clears the parser to magic search, empties the queue and
//   sets slot_size to 256.
// ----------------------------------------------------------------------------
module slotted_record_stream_parser_top import srsp_pkg::*; #(
  parameter int unsigned SlotW = SlotSizeW,
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SlotW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // in_byte
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // event_kind[3:0], field_code[35:4], field_value[99:36], out_byte[107:100]
  output logic [111:0]          m_axis_tdata
);

  logic [SlotW-1:0] slot_size_q;
  event_t front_ev, q_out, out_q;
  logic   front_v, q_full, q_afull, q_empty, q_pop, out_v_q, fe_v_q, byte_acc;
  event_t fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_size_q <= SlotW'(SlotSizeRst);
    end else if (cfg_we_i) begin
      slot_size_q <= cfg_wdata_i;
    end
  end

  // Accept only when the queue can take this byte's event and the one in
  // the staging register.
  assign s_axis_tready = !q_full && !(fe_v_q && q_afull);
  assign byte_acc      = s_axis_tvalid && s_axis_tready;

  srsp_front #(.SlotW(SlotW)) u_front (
    .clk_i, .rst_ni,
    .slot_size_i (slot_size_q),
    .byte_valid_i(byte_acc),
    .byte_i      (s_axis_tdata),
    .ev_o        (front_ev),
    .ev_valid_o  (front_v)
  );

  always_ff @(posedge clk_i) begin
    fe_q <= front_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_v_q <= 1'b0;
    end else begin
      fe_v_q <= front_v;
    end
  end

  srsp_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni,
    .push_data_i  (fe_q),
    .push_i       (fe_v_q),
    .full_o       (q_full),
    .almost_full_o(q_afull),
    .pop_data_o   (q_out),
    .empty_o      (q_empty),
    .pop_i        (q_pop)
  );

  assign q_pop = !q_empty && (!out_v_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      out_q <= q_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (q_pop) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_q.data, out_q.value, out_q.code, out_q.kind};

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_v_q |-> !q_full)
    else $error("event pushed into a full queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped under stall");

endmodule
`default_nettype wire

/* sim/srsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsp_checker: event checker for the slotted record stream parser
// Watches the byte channel, the slot size register and the event channel,
// predicts the event of every accepted byte and compares each event word
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module srsp_checker import srsp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [19:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [111:0] m_axis_tdata,
  output int                fail_count,
  output int                pending
);

  event_t      event_due_q[$];
  logic [19:0] slot_size;
  phase_e      phase;
  logic [31:0] slot_off;
  logic [31:0] hdr_word;
  logic [31:0] area_end;
  logic [63:0] vint_acc;
  logic [3:0]  vint_groups;
  logic [31:0] rec_code;
  logic [31:0] blob_left;

  initial fail_count = 0;
  assign pending = event_due_q.size();

  task automatic report(input string what, input event_t got, input event_t want);
    $write("[%0t] mismatch (%s): got kind %0d code %h value %h byte %h, ",
           $time, what, got.kind, got.code, got.value, got.data);
    $display("want kind %0d code %h value %h byte %h",
             want.kind, want.code, want.value, want.data);
    fail_count++;
  endtask

  function automatic event_t make_event(ev_kind_e k, logic [31:0] c, logic [63:0] v,
                                        logic [7:0] d);
    event_t e;
    e.kind  = k;
    e.code  = c;
    e.value = v;
    e.data  = d;
    return e;
  endfunction

  // Returns 1 on the last group of a varint.
  function automatic bit feed_group(logic [7:0] b);
    if (vint_groups < 4'd10) begin
      vint_acc    = vint_acc | (64'(b[6:0]) << (7 * vint_groups));
      vint_groups = vint_groups + 4'd1;
    end
    return !b[7];
  endfunction

  function automatic void clear_varint();
    vint_acc    = '0;
    vint_groups = '0;
  endfunction

  function automatic void record_done(logic [31:0] off);
    phase = (off + 32'd1 >= area_end) ? PH_CLOSING : PH_TYPE;
  endfunction

  // Advances the parser by one byte; has_ev tells whether an event is due.
  task automatic parse_byte(input logic [7:0] b, output bit has_ev, output event_t ev);
    logic [31:0] off;
    logic [31:0] slot_end;
    off      = slot_off;
    slot_end = {12'd0, slot_size} + 32'd8;
    has_ev   = 0;
    ev       = '0;
    if (phase != PH_MAGIC && off >= slot_end) begin
      if (phase == PH_CLOSING) begin
        has_ev = 1;
        ev     = make_event(EV_ITEM_END, '0, '0, '0);
      end else if (phase != PH_SKIP) begin
        has_ev = 1;
        ev     = make_event(EV_OVERRUN, '0, '0, '0);
      end
      phase    = PH_MAGIC;
      hdr_word = {24'd0, b};
      slot_off = 32'd1;
      return;
    end
    if (phase inside {PH_MAGIC, PH_LEN, PH_SEQ}) begin
      if (off[1:0] == 2'd0) hdr_word = {24'd0, b};
      else hdr_word = hdr_word | ({24'd0, b} << (8 * off[1:0]));
    end
    case (phase)
      PH_MAGIC: begin
        if (off >= 32'd3) begin
          if (hdr_word == MagicWord) begin
            phase = PH_LEN;
          end else begin
            has_ev   = 1;
            ev       = make_event(EV_BAD_MAGIC, '0, {32'd0, hdr_word}, '0);
            slot_off = '0;
            return;
          end
        end
      end
      PH_LEN: begin
        if (off >= 32'd7) begin
          area_end = hdr_word[31] ? 32'd0 : hdr_word + 32'd8;
          phase    = PH_SEQ;
        end
      end
      PH_SEQ: begin
        if (off >= 32'd11) begin
          has_ev = 1;
          ev     = make_event(EV_ITEM_START, '0, {32'd0, hdr_word}, '0);
          phase  = PH_PAD;
        end
      end
      PH_PAD: begin
        if (off >= RecStart - 32'd1) phase = (RecStart >= area_end) ? PH_CLOSING : PH_TYPE;
      end
      PH_TYPE: begin
        clear_varint();
        if (b == 8'd0) phase = PH_CODE_INT;
        else if (b == 8'd3) phase = PH_CODE_STR;
        else if (b == 8'd4) phase = PH_CODE_BLOB;
        else begin
          has_ev = 1;
          ev     = make_event(EV_UNKNOWN, '0, '0, b);
          phase  = PH_SKIP;
        end
      end
      PH_CODE_INT, PH_CODE_STR, PH_CODE_BLOB: begin
        if (feed_group(b)) begin
          rec_code = vint_acc[31:0];
          clear_varint();
          if (phase == PH_CODE_INT) phase = PH_INTVAL;
          else if (phase == PH_CODE_STR) phase = PH_STR;
          else phase = PH_BLOBLEN;
        end
      end
      PH_INTVAL: begin
        if (feed_group(b)) begin
          has_ev = 1;
          ev     = make_event(EV_INT, rec_code, vint_acc, '0);
          clear_varint();
          record_done(off);
        end
      end
      PH_STR: begin
        has_ev = 1;
        if (b != 8'd0) begin
          ev = make_event(EV_STR_BYTE, rec_code, '0, b);
        end else begin
          ev = make_event(EV_STR_END, rec_code, '0, '0);
          record_done(off);
        end
      end
      PH_BLOBLEN: begin
        if (feed_group(b)) begin
          has_ev    = 1;
          ev        = make_event(EV_BLOB_START, rec_code, vint_acc, '0);
          blob_left = (vint_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vint_acc[31:0];
          clear_varint();
          if (blob_left == '0) record_done(off);
          else phase = PH_BLOBDATA;
        end
      end
      PH_BLOBDATA: begin
        has_ev = 1;
        ev     = make_event(EV_BLOB_BYTE, rec_code, '0, b);
        if (blob_left != '0) blob_left = blob_left - 32'd1;
        if (blob_left == '0) record_done(off);
      end
      PH_CLOSING: begin
        has_ev = 1;
        ev     = make_event(EV_ITEM_END, '0, '0, '0);
        phase  = PH_SKIP;
      end
      default: phase = PH_SKIP;
    endcase
    slot_off = off + 32'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit     has_ev;
    event_t ev;
    event_t got;
    if (!rst_ni) begin
      slot_size = 20'(SlotSizeRst);
      phase     = PH_MAGIC;
      slot_off  = '0;
      hdr_word  = '0;
      area_end  = '0;
      vint_acc  = '0;
      vint_groups = '0;
      rec_code  = '0;
      blob_left = '0;
      event_due_q.delete();
    end else begin
      // A byte taken at the same edge as a register write still sees the old size.
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, has_ev, ev);
        if (has_ev) event_due_q.push_back(ev);
      end
      if (cfg_we_i) slot_size = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = ev_kind_e'(m_axis_tdata[3:0]);
        got.code  = m_axis_tdata[35:4];
        got.value = m_axis_tdata[99:36];
        got.data  = m_axis_tdata[107:100];
        if (event_due_q.size() == 0) begin
          report("no event pending", got, '0);
        end else begin
          ev = event_due_q.pop_front();
          if (got.kind != ev.kind) report("event_kind", got, ev);
          else if (got.code != ev.code) report("field_code", got, ev);
          else if (got.value != ev.value) report("field_value", got, ev);
          else if (got.data != ev.data) report("out_byte", got, ev);
        end
      end
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the slotted record stream parser
// Streams directed and random slots (well-formed, truncated, corrupted and
// overrunning) at several slot sizes with random gaps and back-pressure; the
// checker predicts and compares every event word.
// ----------------------------------------------------------------------------
module tb;
  import srsp_pkg::*;

  localparam int ByteTarget = 1450;
  localparam int CycleLimit = 3000000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [19:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           bytes_sent = 0;
  bit           calm = 0;
  int           sink_hold = 0;
  logic [19:0]  cur_slot_size = 20'(SlotSizeRst);
  logic [7:0]   stream_q[$];

  slotted_record_stream_parser_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  srsp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Event sink: mostly short stalls, now and then a long one, with calm stretches.
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1;
      if (!calm) begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  sink_hold <= $urandom_range(1, 3);
          [15:16]: sink_hold <= $urandom_range(10, 40);
          default: sink_hold <= 0;
        endcase
      end
    end
  end

  task automatic push_varint(input logic [63:0] v, input int extra);
    int groups;
    groups = 1;
    while (groups < 10 && (v >> (7 * groups)) != 0) groups++;
    for (int g = 0; g < groups + extra; g++) begin
      logic [7:0] b;
      b = (g < groups) ? {1'b0, 7'(v >> (7 * g))} : 8'd0;
      if (g < groups + extra - 1) b[7] = 1;
      stream_q.push_back(b);
    end
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_q.push_back(w[8*i +: 8]);
  endtask

  // One random record; type bytes other than the three known ones are rare.
  task automatic push_record();
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        stream_q.push_back(8'd0);
        push_varint($urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                               : 64'($urandom_range(0, 300)), 0);
        case ($urandom_range(0, 3))
          0: push_varint({$urandom, $urandom}, 0);
          1: push_varint(64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, 3));
          default: push_varint(64'($urandom_range(0, 200)), $urandom_range(0, 1));
        endcase
      end
      4, 5, 6: begin
        stream_q.push_back(8'd3);
        push_varint(64'($urandom_range(0, 1000)), 0);
        n = $urandom_range(0, 6);
        repeat (n) stream_q.push_back(8'($urandom_range(1, 255)));
        stream_q.push_back(8'd0);
      end
      7, 8, 9: begin
        stream_q.push_back(8'd4);
        push_varint(64'($urandom_range(0, 127)), 0);
        n = $urandom_range(0, 5);
        push_varint(64'(n), 0);
        repeat (n) stream_q.push_back(8'($urandom));
      end
      10: stream_q.push_back(8'($urandom_range(5, 255)));
      default: begin
        // Blob length beyond 32 bits: the slot overruns.
        stream_q.push_back(8'd4);
        push_varint(64'($urandom), 0);
        push_varint({$urandom_range(1, 'hFFFF), $urandom}, 0);
        repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom));
      end
    endcase
  endtask

  task automatic push_slot();
    int start;
    int rec_start;
    int rec_bytes;
    logic [31:0] len;
    start = stream_q.size();
    push_word(MagicWord);
    push_word('0);
    push_word($urandom);
    repeat (5) stream_q.push_back(8'($urandom));
    rec_start = stream_q.size();
    repeat ($urandom_range(0, 3)) push_record();
    rec_bytes = stream_q.size() - rec_start;
    case ($urandom_range(0, 9))
      7: len = $urandom_range(0, int'(cur_slot_size) + 20);
      8: len = $urandom | 32'h8000_0000;
      9: len = 0;
      default: len = rec_bytes + 9;
    endcase
    for (int i = 0; i < 4; i++) stream_q[start + 4 + i] = len[8*i +: 8];
    if ($urandom_range(0, 7) == 0) begin
      // Truncated slot: the rest gets parsed as part of it.
      while (stream_q.size() > start + 1 && $urandom_range(0, 3) != 0) void'(stream_q.pop_back());
    end else if (cur_slot_size <= 300) begin
      while (stream_q.size() - start < int'(cur_slot_size) + 8)
        stream_q.push_back(8'($urandom));
    end
  endtask

  // Drains the byte queue; valid stays high across back-to-back words.
  task automatic send_stream();
    int gap;
    while (stream_q.size() > 0) begin
      s_axis_tdata  <= stream_q.pop_front();
      s_axis_tvalid <= 1;
      do @(posedge clk_i); while (!s_axis_tready);
      bytes_sent++;
      @(negedge clk_i);
      if (calm) gap = 0;
      else case ($urandom_range(0, 99)) inside
        [0:59]:  gap = 0;
        [60:91]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(8, 30);
      endcase
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 0;
  endtask

  task automatic write_slot_size(input logic [19:0] v);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i      <= 1;
    cfg_wdata_i   <= v;
    cur_slot_size = v;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    int slots;
    int phase_no;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: one slot with extreme fields and an unknown type, shorter than the slot size.
    write_slot_size(20'd60);
    push_word(MagicWord);
    push_word(32'd40);
    push_word(32'hFFFF_FFFF);
    repeat (5) stream_q.push_back(8'hFF);
    stream_q.push_back(8'd0);
    push_varint(64'hFFFF_FFFF, 0);
    push_varint(64'hFFFF_FFFF_FFFF_FFFF, 0);
    stream_q.push_back(8'd3);
    stream_q.push_back(8'd1);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'd0);
    stream_q.push_back(8'd4);
    stream_q.push_back(8'd2);
    stream_q.push_back(8'd1);
    stream_q.push_back(8'h80);
    stream_q.push_back(8'hFF);
    repeat (4) stream_q.push_back(8'h00);
    send_stream();

    slots = 0;
    phase_no = 0;
    while (bytes_sent < ByteTarget) begin
      if (slots % 6 == 0) begin
        case (phase_no)
          0: write_slot_size(20'd0);
          1: write_slot_size(20'hFFFFF);
          default: case ($urandom_range(0, 9))
            0: write_slot_size(20'd0);
            1: write_slot_size(20'hFFFFF);
            2: write_slot_size(20'($urandom_range(1, 16)));
            default: write_slot_size(20'($urandom_range(20, 120)));
          endcase
        endcase
        phase_no++;
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom));
      push_slot();
      send_stream();
      slots++;
    end

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* slotted_record_stream_parser_top.f */
rtl/core/srsp_pkg.sv
rtl/core/srsp_front.sv
rtl/core/srsp_queue.sv
rtl/core/slotted_record_stream_parser_top.sv
sim/srsp_checker.sv
sim/tb.sv
